// ===== src/spectrum_bin_smooth_peak_hold_defines.svh =====
// assertion macros for the spectrum bin smoothing and peak hold block
// no dependencies; included by the top level only
`ifndef SPECTRUM_BIN_SMOOTH_PEAK_HOLD_DEFINES_SVH
`define SPECTRUM_BIN_SMOOTH_PEAK_HOLD_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SBSPH_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SBSPH_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sbsph_pkg.sv =====
// shared types, widths, register codes and reset values
// no dependencies; imported by every module of the block but sbsph_ram
package sbsph_pkg;

	localparam int BIN_W      = 9;
	localparam int LEVEL_W    = 16;
	localparam int HOLD_W     = 8;
	localparam int GAIN_W     = 16;
	localparam int STEP_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ENTRY_W    = 2 * LEVEL_W + HOLD_W;

	// output queue sizing
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	typedef logic [BIN_W-1:0]           bin_t;
	typedef logic signed [LEVEL_W-1:0]  level_t;
	typedef logic [HOLD_W-1:0]          hold_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_SMOOTH_GAIN    = 3'd0;
	localparam cfg_idx_t REG_HOLD_FRAMES    = 3'd1;
	localparam cfg_idx_t REG_PEAK_FALL_STEP = 3'd2;
	localparam cfg_idx_t REG_UNDERRUN_DECAY = 3'd3;
	localparam cfg_idx_t REG_FLOOR_LEVEL    = 3'd4;

	// register reset values
	localparam gain_t  GAIN_RESET  = 16'd52429;
	localparam hold_t  HOLD_RESET  = 8'd30;
	localparam step_t  STEP_RESET  = 15'd128;
	localparam step_t  DECAY_RESET = 15'd256;
	localparam level_t FLOOR_RESET = -16'sd25600;

	localparam level_t LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

	typedef struct packed {
		gain_t  smooth_gain;
		hold_t  hold_frames;
		step_t  peak_fall_step;
		step_t  underrun_decay;
		level_t floor_level;
	} cfg_t;

	// one bin's stored state
	typedef struct packed {
		level_t smoothed;
		level_t peak;
		hold_t  hold;
	} entry_t;

	// input word as carried down the pipeline
	typedef struct packed {
		bin_t   bin;
		logic   in_range;
		level_t raw;
		logic   under;
	} item_t;

	typedef struct packed {
		bin_t   bin;
		level_t smoothed;
		level_t peak;
	} result_t;

	// occupancy of a pipeline stage, used for the bin interlock
	typedef struct packed {
		logic valid;
		logic in_range;
		bin_t bin;
	} stage_status_t;

endpackage

// ===== src/spectrum_bin_smooth_peak_hold.sv =====
// Per-bin display ballistics for a spectrum meter: smoothed level, held peak
// and hold count per bin, all kept in one ram word per bin.
//
// Input channel (in_valid / in_stall): one word per frequency bin with
// bin_index, raw_level (Q7.8 dB) and underrun. Output channel (out_valid /
// out_stall): one result word per input word, in order, with out_bin,
// smoothed_level and peak_level. Registers are written through cfg_we,
// cfg_index and cfg_data by the user, only while the block is idle; unchecked.
// Throughput: one word per cycle while each word names a bin other than the
// two accepted before it and the output queue has room. A word for a bin still
// in the two-stage read-modify-write loop is held off until that bin is written
// back. A result passes the stage one and stage two registers and the output
// queue before out_valid rises.
// After reset the state ram is swept to the floor reset level and a zero
// hold count, one bin per cycle over all BIN_COUNT bins, with in_stall high.
// When the receiver stalls, up to four results queue in the output buffer
// and in_stall rises once the queue and pipeline together are full.
// Depends on sbsph_pkg, sbsph_ram, sbsph_update, sbsph_outq and the defines header.
module spectrum_bin_smooth_peak_hold #(
	parameter int BIN_COUNT = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sbsph_pkg::bin_t              bin_index,
	input  sbsph_pkg::level_t            raw_level,
	input  logic                         underrun,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sbsph_pkg::bin_t              out_bin,
	output sbsph_pkg::level_t            smoothed_level,
	output sbsph_pkg::level_t            peak_level,
	input  logic                         cfg_we,
	input  sbsph_pkg::cfg_idx_t          cfg_index,
	input  logic [sbsph_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbsph_pkg::*;

`include "spectrum_bin_smooth_peak_hold_defines.svh"

	localparam int AW    = $clog2(BIN_COUNT);
	localparam int EXT_W = ((AW > BIN_W) ? AW : BIN_W) + 1;

	cfg_t                   cfg_q;
	logic                   clr_active_q;
	logic [AW-1:0]          clr_addr_q;

	logic [EXT_W-1:0]       bin_ext;
	logic                   in_range;
	logic                   hazard;
	logic                   credit_ok;
	logic [OUTQ_CNT_W:0]    inflight;
	logic                   in_acc;

	logic                   v_s1;
	item_t                  item_s1;
	entry_t                 old_s1;

	stage_status_t          st_s2;
	logic                   upd_we;
	entry_t                 upd_entry;
	logic                   res_valid;
	result_t                res;
	logic [AW-1:0]          upd_addr;

	logic                   ram_we;
	logic [AW-1:0]          ram_wr_addr;
	entry_t                 ram_wr_data;
	logic                   ram_rd_en;
	logic [AW-1:0]          ram_rd_addr;
	logic [ENTRY_W-1:0]     ram_rd_data;

	logic [OUTQ_CNT_W-1:0]  q_count;
	result_t                q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smooth_gain    <= GAIN_RESET;
			cfg_q.hold_frames    <= HOLD_RESET;
			cfg_q.peak_fall_step <= STEP_RESET;
			cfg_q.underrun_decay <= DECAY_RESET;
			cfg_q.floor_level    <= FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SMOOTH_GAIN:    cfg_q.smooth_gain    <= cfg_data[GAIN_W-1:0];
				REG_HOLD_FRAMES:    cfg_q.hold_frames    <= cfg_data[HOLD_W-1:0];
				REG_PEAK_FALL_STEP: cfg_q.peak_fall_step <= cfg_data[STEP_W-1:0];
				REG_UNDERRUN_DECAY: cfg_q.underrun_decay <= cfg_data[STEP_W-1:0];
				REG_FLOOR_LEVEL:    cfg_q.floor_level    <= level_t'(cfg_data[LEVEL_W-1:0]);
				default: ;
			endcase
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == AW'(BIN_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// bin range check and same-bin interlock against the two stages in flight
	assign bin_ext   = EXT_W'(bin_index);
	assign in_range  = (bin_ext < EXT_W'(BIN_COUNT));
	assign hazard    = (v_s1 && item_s1.in_range && (item_s1.bin == bin_index))
	                 || (st_s2.valid && st_s2.in_range && (st_s2.bin == bin_index));
	assign inflight  = (OUTQ_CNT_W + 1)'(v_s1) + (OUTQ_CNT_W + 1)'(st_s2.valid)
	                 + (OUTQ_CNT_W + 1)'(q_count);
	assign credit_ok = (inflight < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
	assign in_stall  = clr_active_q | ~credit_ok | hazard;
	assign in_acc    = in_valid & ~in_stall;

	// stage one word register, ram read issued on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.bin      <= bin_index;
			item_s1.in_range <= in_range;
			item_s1.raw      <= raw_level;
			item_s1.under    <= underrun;
		end
	end

	assign ram_rd_en   = in_acc & in_range;
	assign ram_rd_addr = bin_ext[AW-1:0];
	assign old_s1      = entry_t'(ram_rd_data);

	// write port: clearing sweep or pipeline write-back
	assign upd_addr              = AW'(st_s2.bin);
	assign ram_we                = clr_active_q | upd_we;
	assign ram_wr_addr           = clr_active_q ? clr_addr_q : upd_addr;
	assign ram_wr_data.smoothed  = clr_active_q ? FLOOR_RESET : upd_entry.smoothed;
	assign ram_wr_data.peak      = clr_active_q ? FLOOR_RESET : upd_entry.peak;
	assign ram_wr_data.hold      = clr_active_q ? '0 : upd_entry.hold;

	sbsph_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(BIN_COUNT)
	) u_state_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sbsph_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (v_s1),
		.item_s1   (item_s1),
		.old_s1    (old_s1),
		.cfg       (cfg_q),
		.status_s2 (st_s2),
		.wr_en     (upd_we),
		.wr_entry  (upd_entry),
		.res_valid (res_valid),
		.res       (res)
	);

	sbsph_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (q_data),
		.count     (q_count)
	);

	assign out_bin        = q_data.bin;
	assign smoothed_level = q_data.smoothed;
	assign peak_level     = q_data.peak;

	// checks on the interlock, the sweep and the queue credit
	`SBSPH_ASSERT_NOW(a_no_rw_clash, clk, arst_n, ram_rd_en && upd_we, ram_rd_addr != upd_addr, "read of a bin being written back")
	`SBSPH_ASSERT_NOW(a_clear_quiet, clk, arst_n, clr_active_q, !upd_we && !v_s1, "pipeline active during clearing sweep")
	`SBSPH_ASSERT_NOW(a_queue_credit, clk, arst_n, 1'b1, inflight <= (OUTQ_CNT_W + 1)'(OUTQ_DEPTH), "output queue overcommitted")
	`SBSPH_ASSERT_NEXT(a_clear_once, clk, arst_n, !clr_active_q, !clr_active_q, "clearing sweep restarted")

endmodule

// ===== src/sbsph_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sbsph_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read, read returns the old contents on a clash
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/sbsph_update.sv =====
// two-stage level update: blend product and underrun path, then peak hold
// depends on sbsph_pkg
module sbsph_update (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s1,
	input  sbsph_pkg::item_t         item_s1,
	input  sbsph_pkg::entry_t        old_s1,
	input  sbsph_pkg::cfg_t          cfg,
	output sbsph_pkg::stage_status_t status_s2,
	output logic                     wr_en,
	output sbsph_pkg::entry_t        wr_entry,
	output logic                     res_valid,
	output sbsph_pkg::result_t       res
);
	import sbsph_pkg::*;

	localparam int DIFF_W = LEVEL_W + 1;
	localparam int PROD_W = 2 * (GAIN_W + 1);
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(2 ** (GAIN_W - 1));

	// clamp a difference that can only run out of range downwards
	function automatic level_t sat_low(input logic signed [DIFF_W-1:0] v);
		if (v[DIFF_W-1] != v[DIFF_W-2]) begin
			sat_low = LEVEL_MIN;
		end else begin
			sat_low = v[LEVEL_W-1:0];
		end
	endfunction

	function automatic level_t lvl_max(input level_t a, input level_t b);
		lvl_max = (a > b) ? a : b;
	endfunction

	level_t                    s_old, p_old;
	hold_t                     h_old;
	logic signed [DIFF_W-1:0]  mix_diff, fall_diff, dec_diff;
	logic signed [PROD_W-1:0]  prod_c;
	level_t                    fallen_c, s_dec_c, s_u_c, p_hf_c, p_u_c;
	hold_t                     h_u_c;

	logic                      valid_s2;
	item_t                     item_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	level_t                    peak_s2, fallen_s2, s_u_s2, p_u_s2;
	hold_t                     hold_s2, h_u_s2;

	logic signed [PROD_W-1:0]  rnd_sum;
	level_t                    s_n, p_n, s_new, p_new;
	hold_t                     h_n, h_new;

	assign s_old = old_s1.smoothed;
	assign p_old = old_s1.peak;
	assign h_old = old_s1.hold;

	// first stage: blend product, fallen peak and the whole underrun update
	always_comb begin
		mix_diff  = $signed({s_old[LEVEL_W-1], s_old})
		          - $signed({item_s1.raw[LEVEL_W-1], item_s1.raw});
		prod_c    = $signed({1'b0, cfg.smooth_gain}) * mix_diff;
		fall_diff = $signed({p_old[LEVEL_W-1], p_old}) - $signed({2'b00, cfg.peak_fall_step});
		dec_diff  = $signed({s_old[LEVEL_W-1], s_old}) - $signed({2'b00, cfg.underrun_decay});
		fallen_c  = sat_low(fall_diff);
		s_dec_c   = sat_low(dec_diff);
		s_u_c     = lvl_max(s_dec_c, cfg.floor_level);
		if (h_old != '0) begin
			p_hf_c = p_old;
			h_u_c  = h_old - 1'b1;
		end else begin
			p_hf_c = lvl_max(s_u_c, fallen_c);
			h_u_c  = h_old;
		end
		p_u_c = lvl_max(p_hf_c, cfg.floor_level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s2   <= item_s1;
		prod_s2   <= prod_c;
		peak_s2   <= p_old;
		hold_s2   <= h_old;
		fallen_s2 <= fallen_c;
		s_u_s2    <= s_u_c;
		p_u_s2    <= p_u_c;
		h_u_s2    <= h_u_c;
	end

	// second stage: round the blend, capture or hold the peak
	always_comb begin
		rnd_sum = prod_s2 + ROUND_BIAS;
		s_n     = item_s2.raw + level_t'(rnd_sum[GAIN_W+LEVEL_W-1:GAIN_W]);
		if (s_n >= peak_s2) begin
			p_n = s_n;
			h_n = cfg.hold_frames;
		end else if (hold_s2 != '0) begin
			p_n = peak_s2;
			h_n = hold_s2 - 1'b1;
		end else begin
			p_n = lvl_max(s_n, fallen_s2);
			h_n = hold_s2;
		end
		if (item_s2.under) begin
			s_new = s_u_s2;
			p_new = p_u_s2;
			h_new = h_u_s2;
		end else begin
			s_new = s_n;
			p_new = p_n;
			h_new = h_n;
		end
	end

	assign wr_en             = valid_s2 & item_s2.in_range;
	assign wr_entry.smoothed = s_new;
	assign wr_entry.peak     = p_new;
	assign wr_entry.hold     = h_new;

	// bins outside the store report the floor
	assign res_valid    = valid_s2;
	assign res.bin      = item_s2.bin;
	assign res.smoothed = item_s2.in_range ? s_new : cfg.floor_level;
	assign res.peak     = item_s2.in_range ? p_new : cfg.floor_level;

	assign status_s2.valid    = valid_s2;
	assign status_s2.in_range = item_s2.in_range;
	assign status_s2.bin      = item_s2.bin;

endmodule

// ===== src/sbsph_outq.sv =====
// small result queue that decouples the pipeline from the receiver
// depends on sbsph_pkg
module sbsph_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  sbsph_pkg::result_t                  push_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sbsph_pkg::result_t                  out_data,
	output logic [sbsph_pkg::OUTQ_CNT_W-1:0]    count
);
	import sbsph_pkg::*;

	result_t                 buf_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CNT_W-1:0]   count_q;
	logic                    pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign out_data  = buf_q[rd_ptr_q];
	assign count     = count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== sim/spectrum_bin_smooth_peak_hold_tb.sv =====
// testbench for spectrum_bin_smooth_peak_hold: directed and random bin words,
// per-bin ballistics predicted in a scoreboard class and checked word by word
// depends on sbsph_pkg and the spectrum_bin_smooth_peak_hold top level
`timescale 1ns / 100ps

module spectrum_bin_smooth_peak_hold_tb;
	import sbsph_pkg::*;

	localparam int BINS         = 512;
	localparam int DRAIN_CYCLES = 8;
	localparam int SHOWN_ERRORS = 30;
	// an index past the last register, writes to it must be ignored
	localparam cfg_idx_t REG_NONE = 3'd7;

	// per-bin smoothing and peak hold prediction with its own register copy
	class ballistics_board;
		int gain, hold_frames, fall_step, decay, floor_lvl;
		int smoothed [BINS];
		int peak [BINS];
		int hold_left [BINS];
		result_t pending [$];
		int errors, words, underruns, captures, falls, settings;

		function new();
			gain        = int'(GAIN_RESET);
			hold_frames = int'(HOLD_RESET);
			fall_step   = int'(STEP_RESET);
			decay       = int'(DECAY_RESET);
			floor_lvl   = int'(FLOOR_RESET);
			foreach (smoothed[i]) begin
				smoothed[i]  = int'(FLOOR_RESET);
				peak[i]      = int'(FLOOR_RESET);
				hold_left[i] = 0;
			end
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SMOOTH_GAIN: gain = int'(data);
				REG_HOLD_FRAMES: hold_frames = int'(data[HOLD_W-1:0]);
				REG_PEAK_FALL_STEP: fall_step = int'(data[STEP_W-1:0]);
				REG_UNDERRUN_DECAY: decay = int'(data[STEP_W-1:0]);
				REG_FLOOR_LEVEL: floor_lvl = int'(level_t'(data));
				default: ;
			endcase
		endfunction

		function int sat16(int v);
			if (v < -32768)
				return -32768;
			if (v > 32767)
				return 32767;
			return v;
		endfunction

		// exponential average, rounded half up
		function int blend(int prior, int raw);
			longint acc;
			acc = longint'(gain) * prior + longint'(65536 - gain) * raw;
			return sat16(int'((acc + 32768) >>> 16));
		endfunction

		// count the hold down, or let the peak fall towards the smoothed level
		function void hold_or_fall(int i, int s);
			int fallen;
			if (hold_left[i] > 0) begin
				hold_left[i]--;
			end else begin
				fallen = sat16(peak[i] - fall_step);
				peak[i] = (s > fallen) ? s : fallen;
				falls++;
			end
		endfunction

		function void note_word(bin_t b, level_t raw_in, logic under);
			int i, s;
			result_t due;
			i = int'(b);
			words++;
			if (under) begin
				underruns++;
				s = sat16(smoothed[i] - decay);
				if (s < floor_lvl)
					s = floor_lvl;
				smoothed[i] = s;
				hold_or_fall(i, s);
				if (peak[i] < floor_lvl)
					peak[i] = floor_lvl;
			end else begin
				s = blend(smoothed[i], int'(raw_in));
				smoothed[i] = s;
				if (s >= peak[i]) begin
					peak[i] = s;
					hold_left[i] = hold_frames;
					captures++;
				end else begin
					hold_or_fall(i, s);
				end
			end
			due.bin      = b;
			due.smoothed = level_t'(smoothed[i]);
			due.peak     = level_t'(peak[i]);
			pending.push_back(due);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= SHOWN_ERRORS)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_word(bin_t b, level_t s, level_t p);
			result_t due;
			if (pending.size() == 0) begin
				report($sformatf("result for bin %0d with nothing pending", b));
				return;
			end
			due = pending.pop_front();
			if (b !== due.bin)
				report($sformatf("bin %0d, wanted %0d", b, due.bin));
			if (s !== due.smoothed)
				report($sformatf("bin %0d smoothed %0d, wanted %0d", due.bin, s, due.smoothed));
			if (p !== due.peak)
				report($sformatf("bin %0d peak %0d, wanted %0d", due.bin, p, due.peak));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bin_t bin_index = '0;
	level_t raw_level = '0;
	logic underrun = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	bin_t out_bin;
	level_t smoothed_level;
	level_t peak_level;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// set for a stretch with no idling on either side
	bit calm = 1'b0;

	ballistics_board board = new();

	spectrum_bin_smooth_peak_hold #(.BIN_COUNT(BINS)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 8);
	end

	// results are sampled on the falling edge before the accepting edge
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word(out_bin, smoothed_level, peak_level);
	end

	// present one word, wait for acceptance, then maybe idle
	task automatic send_word(bin_t b, level_t r, logic u);
		in_valid  <= 1'b1;
		bin_index <= b;
		raw_level <= r;
		underrun  <= u;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		board.note_word(b, r, u);
		@(posedge clk);
		while (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	// all registers plus the unused index; spare bits fill the unused upper bits
	task automatic set_regs(gain_t g, hold_t h, step_t st, step_t d, level_t f,
			logic [CFG_DATA_W-1:0] spare_bits);
		write_reg(REG_SMOOTH_GAIN, g);
		write_reg(REG_HOLD_FRAMES, {spare_bits[CFG_DATA_W-1:HOLD_W], h});
		write_reg(REG_PEAK_FALL_STEP, {spare_bits[CFG_DATA_W-1], st});
		write_reg(REG_UNDERRUN_DECAY, {spare_bits[CFG_DATA_W-2], d});
		write_reg(REG_FLOOR_LEVEL, f);
		write_reg(REG_NONE, spare_bits);
		cfg_we <= 1'b0;
		board.settings++;
	endtask

	task automatic random_settings();
		gain_t g;
		hold_t h;
		step_t st, d;
		level_t f;
		case ($urandom_range(0, 3))
			0: g = '0;
			1: g = '1;
			default: g = gain_t'($urandom);
		endcase
		h  = ($urandom_range(0, 4) == 0) ? hold_t'($urandom) : hold_t'($urandom_range(0, 5));
		st = ($urandom_range(0, 3) == 0) ? step_t'($urandom) : step_t'($urandom_range(0, 600));
		d  = ($urandom_range(0, 3) == 0) ? step_t'($urandom) : step_t'($urandom_range(0, 900));
		f  = level_t'(-int'($urandom_range(0, 32768)));
		set_regs(g, h, st, d, f, CFG_DATA_W'($urandom));
	endtask

	// mostly a handful of hot bins so each one builds up history
	task automatic random_phase(int n);
		bin_t hot [8];
		bin_t b;
		level_t r;
		int pick;
		foreach (hot[k])
			hot[k] = bin_t'($urandom_range(0, BINS - 1));
		repeat (n) begin
			if ($urandom_range(0, 99) < 80)
				b = hot[$urandom_range(0, 7)];
			else
				b = bin_t'($urandom_range(0, BINS - 1));
			pick = $urandom_range(0, 9);
			if (pick == 0)
				r = LEVEL_MIN;
			else if (pick == 1)
				r = 16'sh7FFF;
			else if (pick < 6)
				r = level_t'(-int'($urandom_range(0, 28000)));
			else
				r = level_t'($urandom_range(0, 65535));
			send_word(b, r, $urandom_range(0, 3) == 0);
		end
	endtask

	// let every pending result come back before touching registers
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fresh bins at the floor, extremes of the level
		send_word(9'd0, 16'sh7FFF, 1'b0);
		send_word(9'd511, LEVEL_MIN, 1'b0);
		send_word(9'd1, 16'sd0, 1'b1);
		send_word(9'd0, 16'sd0, 1'b0);
		send_word(9'd0, 16'sd0, 1'b1);
		send_word(9'd511, 16'sd0, 1'b1);
		send_word(9'h0AA, 16'sh2AAA, 1'b0);
		drain();

		// zero gain, no hold, largest fall and decay, lowest floor
		set_regs('0, '0, '1, '1, LEVEL_MIN, '1);
		send_word(9'd2, LEVEL_MIN, 1'b0);
		send_word(9'd2, 16'sd0, 1'b1);
		send_word(9'd3, 16'sh7FFF, 1'b0);
		send_word(9'd3, LEVEL_MIN, 1'b0);
		send_word(9'd3, 16'sd100, 1'b0);
		send_word(9'd0, 16'sd0, 1'b1);
		drain();

		// full gain, longest hold, no fall or decay, floor raised to zero
		set_regs('1, '1, '0, '0, '0, '0);
		send_word(9'd511, 16'sd0, 1'b1);
		send_word(9'd4, 16'sh7FFF, 1'b0);
		send_word(9'd4, 16'sh7FFF, 1'b0);
		send_word(9'd1, LEVEL_MIN, 1'b1);
		send_word(9'h155, 16'shD555, 1'b0);
		drain();

		// random phases, one on reset settings and one with no idling
		for (int p = 0; p < 4; p++) begin
			if (p == 1)
				set_regs(GAIN_RESET, HOLD_RESET, STEP_RESET, DECAY_RESET, FLOOR_RESET,
					CFG_DATA_W'($urandom));
			else
				random_settings();
			calm = (p == 2);
			random_phase(110);
			drain();
		end

		$display("%0d words checked over %0d register settings, %0d of them underruns",
			board.words, board.settings, board.underruns);
		$display("%0d peaks captured, %0d peak falls, %0d mismatches",
			board.captures, board.falls, board.errors);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
